// ===== src/pfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Power status frame receiver package
// Shared types, codes and defaults for the frame receiver.
// ----------------------------------------------------------------------------
package pfr_pkg;

    localparam int PENDING_MAX_DEF = 63;
    localparam int FRAME_LEN       = 9;

    localparam logic [15:0] TIMEOUT_LIMIT_RST   = 16'd500;
    localparam logic [5:0]  FLUSH_THRESHOLD_RST = 6'd20;

    localparam logic [7:0] HDR_BYTE0 = 8'd2;
    localparam logic [7:0] HDR_BYTE1 = 8'd7;
    localparam logic [7:0] RUN_MASK  = 8'h40;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic REG_TIMEOUT_LIMIT   = 1'b0;
    localparam logic REG_FLUSH_THRESHOLD = 1'b1;

    localparam logic [2:0] ST_NONE  = 3'd0;
    localparam logic [2:0] ST_OK    = 3'd1;
    localparam logic [2:0] ST_BAD   = 3'd2;
    localparam logic [2:0] ST_LEN   = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  frame_status;
        logic [15:0] voltage;
        logic [15:0] current;
        logic        timeout_pulse;
    } t_out_item;

endpackage
`default_nettype wire

// ===== src/power_status_frame_receiver_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Power status frame receiver core
// Collects serial bytes, closes frames on quiet ticks, checks 9-byte frames
// and latches voltage and current (zero when the run bit is clear); raises a link timeout pulse.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                    payload
//  input     in         i_in_valid / o_in_stall      i_in_data  (t_in_item)
//  output    out        o_out_valid / i_out_stall    o_out_data (t_out_item)
//  config    in         APB psel/penable/pwrite      paddr, pwdata, prdata
//
//  One item per cycle unless the input is stalled; each transfer gives one result.
//  State updates at the accepting edge; result goes to an output register.
//  A skid register takes one result while the output is stalled; input
//  stalls only when the skid register is full.
//  Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module power_status_frame_receiver_core
    import pfr_pkg::*;
#(
    parameter int PENDING_MAX = PENDING_MAX_DEF
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int PEND_W = $clog2(PENDING_MAX + 1);
    localparam int CMP_W  = (PEND_W > 6) ? PEND_W : 6;

    logic [15:0] r_timeout_limit;
    logic [5:0]  r_flush_thr;

    logic [7:0]        r_frame [FRAME_LEN];
    logic [PEND_W-1:0] r_pend, n_pend;
    logic [PEND_W-1:0] r_prev, n_prev;
    logic [15:0]       r_tick, n_tick;
    logic [15:0]       r_volt, n_volt;
    logic [15:0]       r_curr, n_curr;

    logic      r_out_vld, r_skid_vld;
    t_out_item r_out, r_skid;
    t_out_item res;

    logic       accept_in, out_fire, cfg_wr, is_final;
    logic [5:0] sum6;
    logic [15:0] tick_inc;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_limit <= TIMEOUT_LIMIT_RST;
            r_flush_thr     <= FLUSH_THRESHOLD_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_TIMEOUT_LIMIT:   r_timeout_limit <= pwdata[15:0];
                REG_FLUSH_THRESHOLD: r_flush_thr     <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TIMEOUT_LIMIT:   prdata = {16'd0, r_timeout_limit};
            REG_FLUSH_THRESHOLD: prdata = {26'd0, r_flush_thr};
            default:             prdata = 32'd0;
        endcase
    end

    // handshake
    assign o_in_stall  = r_skid_vld;
    assign accept_in   = i_in_valid & ~r_skid_vld;
    assign out_fire    = r_out_vld & ~i_out_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // item processing
    assign sum6 = r_frame[2][5:0] + r_frame[3][5:0] + r_frame[4][5:0]
                + r_frame[5][5:0] + r_frame[6][5:0] + r_frame[7][5:0];
    assign is_final = (r_pend != '0) && (r_pend == r_prev);
    assign tick_inc = (r_tick != 16'hFFFF) ? r_tick + 16'd1 : r_tick;

    always_comb begin
        n_pend = r_pend;
        n_prev = r_prev;
        n_tick = r_tick;
        n_volt = r_volt;
        n_curr = r_curr;
        res.frame_status  = ST_NONE;
        res.timeout_pulse = 1'b0;
        if (i_in_data.opcode == OP_BYTE) begin
            if (r_pend < PEND_W'(PENDING_MAX)) begin
                n_pend = r_pend + PEND_W'(1);
            end
        end else if (is_final) begin
            n_pend = '0;
            n_tick = '0;
            if (r_pend != PEND_W'(FRAME_LEN)) begin
                res.frame_status = ST_LEN;
            end else if (r_frame[0] != HDR_BYTE0 || r_frame[1] != HDR_BYTE1
                         || sum6 != r_frame[8][5:0]) begin
                res.frame_status = ST_BAD;
            end else begin
                res.frame_status = ST_OK;
                if ((r_frame[8] & RUN_MASK) != 8'd0) begin
                    n_volt = {r_frame[4], r_frame[5]};
                    n_curr = {r_frame[6], r_frame[7]};
                end else begin
                    n_volt = '0;
                    n_curr = '0;
                end
            end
        end else begin
            n_prev = r_pend;
            n_tick = tick_inc;
            if (CMP_W'(r_pend) > CMP_W'(r_flush_thr)) begin
                n_pend = '0;
                res.frame_status = ST_FLUSH;
            end
            if (tick_inc > r_timeout_limit) begin
                res.timeout_pulse = 1'b1;
                n_tick = '0;
            end
        end
        res.voltage = n_volt;
        res.current = n_curr;
    end

    always_ff @(posedge i_clk) begin
        if (accept_in && i_in_data.opcode == OP_BYTE
            && r_pend < PEND_W'(FRAME_LEN)) begin
            r_frame[r_pend[3:0]] <= i_in_data.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_prev <= '0;
            r_tick <= '0;
            r_volt <= '0;
            r_curr <= '0;
        end else if (accept_in) begin
            r_pend <= n_pend;
            r_prev <= n_prev;
            r_tick <= n_tick;
            r_volt <= n_volt;
            r_curr <= n_curr;
        end
    end

    // output and skid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || out_fire) begin
            r_out_vld  <= r_skid_vld | accept_in;
            r_skid_vld <= 1'b0;
        end else if (accept_in) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || out_fire) begin
            r_out <= r_skid_vld ? r_skid : res;
        end else if (accept_in) begin
            r_skid <= res;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid register full while output register empty");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PEND_W'(PENDING_MAX))
        else $error("pending count beyond its maximum");

    a_no_pulse_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.timeout_pulse) |->
            (o_out_data.frame_status == ST_NONE || o_out_data.frame_status == ST_FLUSH))
        else $error("timeout pulse on a closing tick");

    a_stalled_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |=> (r_out_vld && $stable(r_out)))
        else $error("stalled result changed");

endmodule
`default_nettype wire
